// ----- design/ilmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Indicator LED mode timer package
// Shared codes, register map, configuration struct and helpers.
// ----------------------------------------------------------------------------
package ilmt_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MODE  = 2'd1;
  localparam logic [1:0] CMD_MATCH = 2'd2;

  // LED mode codes
  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_ENROLL     = 3'd1;
  localparam logic [2:0] MODE_MATCH      = 3'd2;
  localparam logic [2:0] MODE_MATCH_OK   = 3'd3;
  localparam logic [2:0] MODE_MATCH_FAIL = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENROLL_BRI     = 3'd0;
  localparam logic [2:0] REG_MATCH_BRI      = 3'd1;
  localparam logic [2:0] REG_MATCH_OK_BRI   = 3'd2;
  localparam logic [2:0] REG_MATCH_FAIL_BRI = 3'd3;
  localparam logic [2:0] REG_MATCH_DUR      = 3'd4;
  localparam logic [2:0] REG_MATCH_OK_DUR   = 3'd5;
  localparam logic [2:0] REG_MATCH_FAIL_DUR = 3'd6;

  localparam int unsigned PADDR_W = 5;

  localparam logic [6:0]  PCT_MAX       = 7'd100;
  localparam logic [15:0] DUR_RESET_VAL = 16'd1000;

  typedef struct packed {
    logic [6:0]  enroll_bri;
    logic [6:0]  match_bri;
    logic [6:0]  match_ok_bri;
    logic [6:0]  match_fail_bri;
    logic [15:0] match_dur;
    logic [15:0] match_ok_dur;
    logic [15:0] match_fail_dur;
  } cfg_t;

  typedef struct packed {
    logic [6:0] brightness;
    logic       power_on;
    logic [2:0] mode;
  } result_t;

  function automatic logic [6:0] clamp_pct(logic [6:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

// ----- design/ilmt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Indicator LED mode timer configuration registers
// APB-style register file holding brightness levels and durations.
// ----------------------------------------------------------------------------
module ilmt_cfg_regs import ilmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enroll_bri     <= '0;
      cfg_q.match_bri      <= '0;
      cfg_q.match_ok_bri   <= '0;
      cfg_q.match_fail_bri <= '0;
      cfg_q.match_dur      <= DUR_RESET_VAL;
      cfg_q.match_ok_dur   <= DUR_RESET_VAL;
      cfg_q.match_fail_dur <= DUR_RESET_VAL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENROLL_BRI:     cfg_q.enroll_bri     <= pwdata[6:0];
        REG_MATCH_BRI:      cfg_q.match_bri      <= pwdata[6:0];
        REG_MATCH_OK_BRI:   cfg_q.match_ok_bri   <= pwdata[6:0];
        REG_MATCH_FAIL_BRI: cfg_q.match_fail_bri <= pwdata[6:0];
        REG_MATCH_DUR:      cfg_q.match_dur      <= pwdata[15:0];
        REG_MATCH_OK_DUR:   cfg_q.match_ok_dur   <= pwdata[15:0];
        REG_MATCH_FAIL_DUR: cfg_q.match_fail_dur <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENROLL_BRI:     prdata = {25'd0, cfg_q.enroll_bri};
      REG_MATCH_BRI:      prdata = {25'd0, cfg_q.match_bri};
      REG_MATCH_OK_BRI:   prdata = {25'd0, cfg_q.match_ok_bri};
      REG_MATCH_FAIL_BRI: prdata = {25'd0, cfg_q.match_fail_bri};
      REG_MATCH_DUR:      prdata = {16'd0, cfg_q.match_dur};
      REG_MATCH_OK_DUR:   prdata = {16'd0, cfg_q.match_ok_dur};
      REG_MATCH_FAIL_DUR: prdata = {16'd0, cfg_q.match_fail_dur};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/ilmt_mode_engine.sv -----
// ----------------------------------------------------------------------------
// Indicator LED mode timer engine
// Mode, level and countdown state with its combinational next-state logic.
// ----------------------------------------------------------------------------
module ilmt_mode_engine import ilmt_pkg::*; #(
  parameter int unsigned ENROLL_BIT = 4,
  parameter int unsigned MATCH_BIT  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] sensor_mode_i,
  input  logic        match_success_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  logic [2:0]  mode_q, mode_d;
  logic [6:0]  level_q, level_d;
  logic [15:0] remain_q, remain_d;
  logic        run_q, run_d;

  always_comb begin
    mode_d   = mode_q;
    level_d  = level_q;
    remain_d = remain_q;
    run_d    = run_q;
    case (cmd_i)
      CMD_TICK: begin
        if (run_q) begin
          if (remain_q <= 16'd1) begin
            mode_d   = MODE_OFF;
            level_d  = '0;
            remain_d = '0;
            run_d    = 1'b0;
          end else begin
            remain_d = remain_q - 16'd1;
          end
        end
      end
      CMD_MODE: begin
        if (sensor_mode_i[ENROLL_BIT]) begin
          // repeated enroll leaves everything alone
          if (mode_q != MODE_ENROLL) begin
            mode_d   = MODE_ENROLL;
            level_d  = clamp_pct(cfg_i.enroll_bri);
            remain_d = '0;
            run_d    = 1'b0;
          end
        end else if (sensor_mode_i[MATCH_BIT]) begin
          if (mode_q != MODE_MATCH) begin
            mode_d   = MODE_MATCH;
            level_d  = clamp_pct(cfg_i.match_bri);
            remain_d = cfg_i.match_dur;
            run_d    = 1'b1;
          end
        end else if (mode_q == MODE_ENROLL || mode_q == MODE_MATCH) begin
          // off only honoured from enroll or match
          mode_d   = MODE_OFF;
          level_d  = '0;
          remain_d = '0;
          run_d    = 1'b0;
        end
      end
      CMD_MATCH: begin
        run_d = 1'b1;
        if (match_success_i) begin
          mode_d   = MODE_MATCH_OK;
          level_d  = clamp_pct(cfg_i.match_ok_bri);
          remain_d = cfg_i.match_ok_dur;
        end else begin
          mode_d   = MODE_MATCH_FAIL;
          level_d  = clamp_pct(cfg_i.match_fail_bri);
          remain_d = cfg_i.match_fail_dur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      level_q  <= '0;
      remain_q <= '0;
      run_q    <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      level_q  <= level_d;
      remain_q <= remain_d;
      run_q    <= run_d;
    end
  end

  assign result_o.brightness = level_d;
  assign result_o.power_on   = |level_d;
  assign result_o.mode       = mode_d;

endmodule

// ----- design/indicator_led_mode_timer_top.sv -----
// ----------------------------------------------------------------------------
// Indicator LED mode timer
// Five-mode indicator LED controller with millisecond countdown.
// ----------------------------------------------------------------------------
// Each request (a 1 ms tick, a sensor mode update or a match result) is taken
// into an input register, processed by the combinational mode engine and
// its result (brightness, power flag, mode) lands in an output register. One
// request per cycle is sustained while the result side keeps taking results.
// While a result waits, the input register still takes one request if it is
// empty. Configuration is via an APB-style port: registers at byte offsets
// 0x00..0x18, brightness values above 100 are treated as 100, durations
// reset to 1000 ms. Write configuration only while the block is idle.
module indicator_led_mode_timer_top import ilmt_pkg::*; #(
  parameter int unsigned ENROLL_BIT = 4,
  parameter int unsigned MATCH_BIT  = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        sensor_mode_i,
  input  logic               match_success_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         brightness_o,
  output logic               power_on_o,
  output logic [2:0]         mode_o
);

  cfg_t    cfg;
  result_t result;

  // input register
  logic        in_vld_q;
  logic [1:0]  cmd_q;
  logic [31:0] sensor_mode_q;
  logic        match_success_q;

  // output register
  logic        out_vld_q;
  result_t     out_q;

  logic out_free; // output register can take a new result this cycle
  logic step;     // request in input register is processed now

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  ilmt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ilmt_mode_engine #(
    .ENROLL_BIT (ENROLL_BIT),
    .MATCH_BIT  (MATCH_BIT)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .cmd_i           (cmd_q),
    .sensor_mode_i   (sensor_mode_q),
    .match_success_i (match_success_q),
    .cfg_i           (cfg),
    .result_o        (result)
  );

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q           <= cmd_i;
      sensor_mode_q   <= sensor_mode_i;
      match_success_q <= match_success_i;
    end
  end

  // output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign brightness_o = out_q.brightness;
  assign power_on_o   = out_q.power_on;
  assign mode_o       = out_q.mode;

endmodule

// ----- tb/sv/indicator_led_mode_timer_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indicator LED mode timer testbench
// Drives tick, sensor mode and match result requests through the request
// channel and checks every result against a cycle-free model of the LED mode
// engine. Both channels idle in random bursts. The result side holds off once
// for a long stretch so the block backs up. Configuration is rewritten over
// the APB port between phases, the extremes included.
// ----------------------------------------------------------------------------
module indicator_led_mode_timer_top_tb;
  import ilmt_pkg::*;

  localparam int unsigned ENROLL_BIT   = 4;
  localparam int unsigned MATCH_BIT    = 2;
  // cmd code with no function: state untouched, current result returned
  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam int unsigned DRAIN_PAD    = 6;      // idle margin after draining
  localparam int unsigned HOLD_CYCLES  = 300;    // long result-side hold-off
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 55;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sm_bits;
    logic        pass_flag;
  } led_req_t;

  // --------------------------------------------------------------------------
  // Block ports: every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [PADDR_W-1:0] paddr           = '0;
  logic [31:0]        pwdata          = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i           = CMD_TICK;
  logic [31:0]        sensor_mode_i   = '0;
  logic               match_success_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [6:0]         brightness_o;
  logic               power_on_o;
  logic [2:0]         mode_o;

  indicator_led_mode_timer_top #(
    .ENROLL_BIT (ENROLL_BIT),
    .MATCH_BIT  (MATCH_BIT)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .sensor_mode_i   (sensor_mode_i),
    .match_success_i (match_success_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .brightness_o    (brightness_o),
    .power_on_o      (power_on_o),
    .mode_o          (mode_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared testbench state
  // --------------------------------------------------------------------------
  led_req_t    requests_pending[$];   // filled by the sequence, drained by the driver
  result_t     led_results_due[$];    // predicted results, oldest first
  bit          req_in_flight = 1'b0;  // a request popped but not yet accepted
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned src_idle_pct  = 0;     // chance per item of a sender idle burst
  int unsigned sink_idle_pct = 0;     // chance per cycle of a receiver stall burst
  bit          hold_req      = 1'b0;
  logic        rx_hold       = 1'b0;

  // Testbench copy of the registers and of the mode engine state
  cfg_t        led_cfg = '{enroll_bri: 7'd0, match_bri: 7'd0, match_ok_bri: 7'd0,
                           match_fail_bri: 7'd0, match_dur: DUR_RESET_VAL,
                           match_ok_dur: DUR_RESET_VAL, match_fail_dur: DUR_RESET_VAL};
  logic [2:0]  st_mode  = MODE_OFF;
  logic [6:0]  st_level = 7'd0;
  logic [15:0] st_rem   = 16'd0;
  logic        st_run   = 1'b0;

  // --------------------------------------------------------------------------
  // Mode engine model
  // --------------------------------------------------------------------------
  // Register values above 100 % are shown as 100 %.
  function automatic logic [6:0] pct_limit(input logic [6:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  // Steady light: countdown stopped
  function automatic void light_steady(input logic [6:0] level);
    st_run   = 1'b0;
    st_rem   = 16'd0;
    st_level = pct_limit(level);
  endfunction

  // Timed light: countdown (re)loaded and running
  function automatic void light_timed(input logic [6:0] level, input logic [15:0] ms);
    st_level = pct_limit(level);
    st_rem   = ms;
    st_run   = 1'b1;
  endfunction

  // Advances the engine by one request and returns the result it shows.
  function automatic result_t next_led_result(input led_req_t r);
    result_t res;
    case (r.cmd)
      CMD_TICK: begin
        // 0 or 1 left expires, so a zero duration behaves like one
        if (st_run) begin
          if (st_rem <= 16'd1) begin
            st_mode = MODE_OFF;
            light_steady(7'd0);
          end else begin
            st_rem = st_rem - 16'd1;
          end
        end
      end
      CMD_MODE: begin
        // enroll bit wins over match bit; a repeated request is a no-op
        if (r.sm_bits[ENROLL_BIT]) begin
          if (st_mode != MODE_ENROLL) begin
            st_mode = MODE_ENROLL;
            light_steady(led_cfg.enroll_bri);
          end
        end else if (r.sm_bits[MATCH_BIT]) begin
          if (st_mode != MODE_MATCH) begin
            st_mode = MODE_MATCH;
            light_timed(led_cfg.match_bri, led_cfg.match_dur);
          end
        end else if (st_mode == MODE_ENROLL || st_mode == MODE_MATCH) begin
          // off only takes effect from enroll or match
          light_steady(7'd0);
          st_mode = MODE_OFF;
        end
      end
      CMD_MATCH: begin
        // match ok / failed always reload
        if (r.pass_flag) begin
          st_mode = MODE_MATCH_OK;
          light_timed(led_cfg.match_ok_bri, led_cfg.match_ok_dur);
        end else begin
          st_mode = MODE_MATCH_FAIL;
          light_timed(led_cfg.match_fail_bri, led_cfg.match_fail_dur);
        end
      end
      default: ;
    endcase
    res.brightness = st_level;
    res.power_on   = (st_level != 7'd0);
    res.mode       = st_mode;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: presents queued requests, predicts at acceptance
  // --------------------------------------------------------------------------
  int unsigned src_gap = 0;

  always @(posedge clk_i) begin : req_driver
    led_req_t cur;
    led_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur = {cmd_i, sensor_mode_i, match_success_i};
        led_results_due.push_back(next_led_result(cur));
        req_in_flight = 1'b0;
      end
      // a request still waiting for ready is left alone
      if (!(in_valid_i && !in_ready_o)) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (requests_pending.size() != 0 && src_idle_pct != 0 &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          // start an idle burst, this cycle included
          src_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          nxt = requests_pending.pop_front();
          req_in_flight = 1'b1;
          in_valid_i      <= 1'b1;
          cmd_i           <= nxt.cmd;
          sensor_mode_i   <= nxt.sm_bits;
          match_success_i <= nxt.pass_flag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted result, drives ready
  // --------------------------------------------------------------------------
  int unsigned sink_gap = 0;

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    logic    rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (led_results_due.size() == 0) begin
          $display("%0t: result with none expected: brightness %0d power %0d mode %0d",
                   $time, brightness_o, power_on_o, mode_o);
          mismatches = mismatches + 1;
        end else begin
          want = led_results_due.pop_front();
          if (brightness_o !== want.brightness) begin
            $display("%0t: brightness expected %0d actual %0d",
                     $time, want.brightness, brightness_o);
            mismatches = mismatches + 1;
          end
          if (power_on_o !== want.power_on) begin
            $display("%0t: power_on expected %0d actual %0d",
                     $time, want.power_on, power_on_o);
            mismatches = mismatches + 1;
          end
          if (mode_o !== want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, mode_o);
            mismatches = mismatches + 1;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        rdy = 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(0, 10);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy && !rx_hold;
    end
  end

  // Long hold-off on the result side, counted here so the sequence can keep
  // feeding requests meanwhile
  initial begin : result_hold_off
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] cmd, input logic [31:0] sm, input logic ok);
    led_req_t r;
    r.cmd       = cmd;
    r.sm_bits   = sm;
    r.pass_flag = ok;
    requests_pending.push_back(r);
  endtask

  // APB write: setup cycle then access cycle. Bits above the field width are
  // sometimes filled with junk; the register keeps only its own width.
  task automatic apb_write(input logic [2:0] idx, input logic [15:0] val,
                           input int unsigned width);
    logic [31:0] data;
    data = {16'd0, val};
    if ($urandom_range(0, 1)) data = ($urandom << width) | data;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENROLL_BRI:     led_cfg.enroll_bri     = data[6:0];
      REG_MATCH_BRI:      led_cfg.match_bri      = data[6:0];
      REG_MATCH_OK_BRI:   led_cfg.match_ok_bri   = data[6:0];
      REG_MATCH_FAIL_BRI: led_cfg.match_fail_bri = data[6:0];
      REG_MATCH_DUR:      led_cfg.match_dur      = data[15:0];
      REG_MATCH_OK_DUR:   led_cfg.match_ok_dur   = data[15:0];
      REG_MATCH_FAIL_DUR: led_cfg.match_fail_dur = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [6:0] eb, input logic [6:0] mb,
                            input logic [6:0] okb, input logic [6:0] fb,
                            input logic [15:0] md, input logic [15:0] okd,
                            input logic [15:0] fd);
    apb_write(REG_ENROLL_BRI,     {9'd0, eb},  7);
    apb_write(REG_MATCH_BRI,      {9'd0, mb},  7);
    apb_write(REG_MATCH_OK_BRI,   {9'd0, okb}, 7);
    apb_write(REG_MATCH_FAIL_BRI, {9'd0, fb},  7);
    apb_write(REG_MATCH_DUR,      md,  16);
    apb_write(REG_MATCH_OK_DUR,   okd, 16);
    apb_write(REG_MATCH_FAIL_DUR, fd,  16);
  endtask

  // Idle: nothing queued, nothing in flight, nothing owed, then a margin
  task automatic wait_drained;
    while (requests_pending.size() != 0 || req_in_flight || led_results_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  function automatic logic [6:0] rand_pct;
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd101;
      3:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [15:0] rand_dur;
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      7:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  localparam logic [31:0] ENROLL_MASK = 32'd1 << ENROLL_BIT;
  localparam logic [31:0] MATCH_MASK  = 32'd1 << MATCH_BIT;

  initial begin : sequence_main
    logic [31:0] sm;
    logic [1:0]  cmd;
    int unsigned k;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed part: brightness clamp, short and zero durations
    set_config(7'd50, 7'd127, 7'd100, 7'd1, 16'd3, 16'd0, 16'd2);
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    push_req(CMD_TICK,  32'd0, 1'b0);                      // tick with no countdown
    push_req(CMD_SPARE, 32'hFFFF_FFFF, 1'b1);              // unused command
    push_req(CMD_MODE,  32'd0, 1'b0);                      // off ignored while off
    push_req(CMD_MODE,  ENROLL_MASK, 1'b0);                // enroll
    push_req(CMD_MODE,  ENROLL_MASK, 1'b1);                // repeated enroll
    push_req(CMD_MODE,  ENROLL_MASK | MATCH_MASK, 1'b0);   // enroll bit takes priority
    push_req(CMD_MODE,  MATCH_MASK, 1'b0);                 // match, 3 ms, clamped level
    push_req(CMD_MODE,  MATCH_MASK, 1'b0);                 // repeated match
    push_req(CMD_TICK,  32'd0, 1'b1);
    push_req(CMD_TICK,  32'd0, 1'b0);
    push_req(CMD_TICK,  32'd0, 1'b0);                      // countdown expires
    push_req(CMD_MODE,  MATCH_MASK, 1'b0);
    push_req(CMD_MODE,  32'd0, 1'b0);                      // off from match
    push_req(CMD_MATCH, 32'd0, 1'b1);                      // match ok, zero duration
    push_req(CMD_TICK,  32'd0, 1'b0);                      // zero duration expires at once
    push_req(CMD_MATCH, 32'hFFFF_FFFF, 1'b0);              // match failed, 2 ms
    push_req(CMD_MODE,  ~(ENROLL_MASK | MATCH_MASK), 1'b0);// off ignored in match failed
    push_req(CMD_MATCH, 32'd0, 1'b1);                      // reload from failed to ok
    push_req(CMD_MATCH, 32'd0, 1'b1);                      // ok always reloads
    push_req(CMD_MODE,  32'd0, 1'b0);                      // off ignored in match ok
    push_req(CMD_MODE,  MATCH_MASK, 1'b0);                 // match from match ok
    push_req(CMD_MODE,  32'hFFFF_FFFF, 1'b0);              // enroll cancels countdown
    push_req(CMD_TICK,  32'd0, 1'b0);                      // no countdown running
    push_req(CMD_MODE,  ~(ENROLL_MASK | MATCH_MASK), 1'b1);// off from enroll
    push_req(CMD_SPARE, 32'h0000_0000, 1'b0);
    wait_drained();

    // Random phases, each with its own register setting
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == 0)
        set_config(7'd127, 7'd101, 7'd100, 7'd99, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else if (p == 1)
        set_config(7'd0, 7'd0, 7'd0, 7'd0, 16'd0, 16'd0, 16'd0);
      else
        set_config(rand_pct(), rand_pct(), rand_pct(), rand_pct(),
                   rand_dur(), rand_dur(), rand_dur());

      case (p % 4)
        0: begin src_idle_pct = 30; sink_idle_pct = 30; end
        1: begin src_idle_pct = 0;  sink_idle_pct = 50; end
        2: begin src_idle_pct = 50; sink_idle_pct = 0;  end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      // the pressure phase offers back to back; the last phase runs flat out
      if (p == 2) src_idle_pct = 0;
      if (p == PHASES - 1) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        sm = $urandom;
        k  = $urandom_range(0, 9);
        if (k < 4) begin
          sm[ENROLL_BIT] = 1'b1;
        end else if (k < 7) begin
          sm[ENROLL_BIT] = 1'b0;
          sm[MATCH_BIT]  = 1'b1;
        end else begin
          sm[ENROLL_BIT] = 1'b0;
          sm[MATCH_BIT]  = 1'b0;
        end
        k = $urandom_range(0, 19);
        if (k < 9)       cmd = CMD_TICK;
        else if (k < 15) cmd = CMD_MODE;
        else if (k < 19) cmd = CMD_MATCH;
        else             cmd = CMD_SPARE;
        push_req(cmd, sm, 1'($urandom_range(0, 1)));
      end

      if (p == 2) hold_req = 1'b1;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ilmt_pkg.sv
design/ilmt_cfg_regs.sv
design/ilmt_mode_engine.sv
design/indicator_led_mode_timer_top.sv
tb/sv/indicator_led_mode_timer_top_tb.sv
